// ===== hw/rtl/tcdm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcdm_pkg
// Shared types and constants of the triple clock divider/multiplier: beat
// payloads, configuration register indexes and fixed widths.
// ----------------------------------------------------------------------------
package tcdm_pkg;

	// Fixed widths of the configuration registers and the prescaler.
	localparam int PRESCALE_WIDTH = 16;
	localparam int SELECT_WIDTH   = 4;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	// Highest usable table index; larger selects saturate here.
	localparam logic [SELECT_WIDTH-1:0] SELECT_MAX = 4'd10;

	// Reset values of the registers.
	localparam logic [PRESCALE_WIDTH-1:0] MASTER_PERIOD_RESET = 16'd176;
	localparam logic [SELECT_WIDTH-1:0]   SELECT_RESET        = 4'd5;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_MASTER_PERIOD = 2'd0,
		REG_B_SELECT      = 2'd1,
		REG_C_SELECT      = 2'd2
	} cfg_reg_t;

	// Input beat: one timer tick.
	typedef struct packed {
		logic advance;
	} tick_beat_t;

	// Result beat: clock levels after the tick.
	typedef struct packed {
		logic clock_a;
		logic clock_b;
		logic clock_c;
		logic sub_tick;
	} level_beat_t;

endpackage

// ===== hw/rtl/tcdm_stream_if.sv =====
// ----------------------------------------------------------------------------
// tcdm_stream_if
// Valid/ready stream channel carrying one payload of a chosen type per beat.
// ----------------------------------------------------------------------------
interface tcdm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tcdm_sub_clock.sv =====
// ----------------------------------------------------------------------------
// tcdm_sub_clock
// One sub-clock: a sub-tick counter with its output level, an optional phase
// reset, and a wrap flag for the sub-tick in which the clock turns on.
// ----------------------------------------------------------------------------
module tcdm_sub_clock #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   resync,
	input  logic [COUNT_WIDTH-1:0] period,
	output logic                   level,
	output logic                   wrapped
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   level_q;
	logic [COUNT_WIDTH-1:0] start_count;
	logic                   start_level;
	logic [COUNT_WIDTH-1:0] inc_count;
	logic [COUNT_WIDTH-1:0] half;
	logic [COUNT_WIDTH-1:0] last;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   level_next;

	// A phase reset loads all ones so the advance below lands on zero.
	always_comb begin
		start_count = resync ? {COUNT_WIDTH{1'b1}} : count_q;
		start_level = resync ? 1'b1 : level_q;
		inc_count   = start_count + COUNT_WIDTH'(1);
		half        = period >> 1;
		last        = period - COUNT_WIDTH'(1);
		count_next  = inc_count;
		level_next  = start_level;
		wrapped     = 1'b0;
		if (inc_count == half) begin
			level_next = 1'b0;
		end
		if (inc_count > last) begin
			count_next = '0;
			level_next = 1'b1;
			wrapped    = step;
		end
	end

	// The level seen in the result is the one after this beat.
	assign level = step ? level_next : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			level_q <= 1'b1;
		end else if (step) begin
			count_q <= count_next;
			level_q <= level_next;
		end
	end

endmodule

// ===== hw/rtl/triple_clock_divider_multiplier.sv =====
// ----------------------------------------------------------------------------
// triple_clock_divider_multiplier
// Prescaled timer ticks drive three sub-clocks: A at a fixed period, B and C
// at table-selected multiples of it, with a phase reset of B or C on a select
// change that takes effect when A next turns on.
//
//   Channel   Dir   Payload                               Handshake
//   tick      in    advance                               valid/ready
//   result    out   clock_a, clock_b, clock_c, sub_tick   valid/ready
//   wr_*      in    register index, data                  write enable only
//
// A beat is accepted every cycle while the result register is empty or
// being emptied. The state updates and the result register loads at the
// edge that accepts the beat. Reset restores the register defaults and
// all counters at once. A stalled result holds, and no further beat is
// accepted until it is taken.
// ----------------------------------------------------------------------------
module triple_clock_divider_multiplier
	import tcdm_pkg::*;
#(
	parameter int BASE_TICKS  = 48,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tcdm_stream_if.sink                tick,
	tcdm_stream_if.source              result,
	input  logic                       wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_DATA_WIDTH-1:0]  wr_data
);

	// Periods in sub-ticks, worked out at elaboration.
	localparam logic [COUNT_WIDTH-1:0] A_PERIOD = COUNT_WIDTH'(BASE_TICKS);
	localparam logic [COUNT_WIDTH-1:0] B_P0  = COUNT_WIDTH'(BASE_TICKS * 8);
	localparam logic [COUNT_WIDTH-1:0] B_P1  = COUNT_WIDTH'(BASE_TICKS * 6);
	localparam logic [COUNT_WIDTH-1:0] B_P2  = COUNT_WIDTH'(BASE_TICKS * 4);
	localparam logic [COUNT_WIDTH-1:0] B_P3  = COUNT_WIDTH'(BASE_TICKS * 3);
	localparam logic [COUNT_WIDTH-1:0] B_P4  = COUNT_WIDTH'(BASE_TICKS * 2);
	localparam logic [COUNT_WIDTH-1:0] B_P5  = COUNT_WIDTH'(BASE_TICKS);
	localparam logic [COUNT_WIDTH-1:0] B_P6  = COUNT_WIDTH'(BASE_TICKS / 2);
	localparam logic [COUNT_WIDTH-1:0] B_P7  = COUNT_WIDTH'(BASE_TICKS / 3);
	localparam logic [COUNT_WIDTH-1:0] B_P8  = COUNT_WIDTH'(BASE_TICKS / 4);
	localparam logic [COUNT_WIDTH-1:0] B_P9  = COUNT_WIDTH'(BASE_TICKS / 6);
	localparam logic [COUNT_WIDTH-1:0] B_P10 = COUNT_WIDTH'(BASE_TICKS / 8);
	localparam logic [COUNT_WIDTH-1:0] C_P0  = COUNT_WIDTH'(BASE_TICKS * 24);
	localparam logic [COUNT_WIDTH-1:0] C_P1  = COUNT_WIDTH'(BASE_TICKS * 12);
	localparam logic [COUNT_WIDTH-1:0] C_P2  = COUNT_WIDTH'(BASE_TICKS * 8);
	localparam logic [COUNT_WIDTH-1:0] C_P3  = COUNT_WIDTH'(BASE_TICKS * 4);
	localparam logic [COUNT_WIDTH-1:0] C_P4  = COUNT_WIDTH'(BASE_TICKS * 2);
	localparam logic [COUNT_WIDTH-1:0] C_P5  = COUNT_WIDTH'(BASE_TICKS);
	localparam logic [COUNT_WIDTH-1:0] C_P6  = COUNT_WIDTH'(BASE_TICKS / 2);
	localparam logic [COUNT_WIDTH-1:0] C_P7  = COUNT_WIDTH'(BASE_TICKS / 4);
	localparam logic [COUNT_WIDTH-1:0] C_P8  = COUNT_WIDTH'(BASE_TICKS / 8);
	localparam logic [COUNT_WIDTH-1:0] C_P9  = COUNT_WIDTH'(BASE_TICKS / 12);
	localparam logic [COUNT_WIDTH-1:0] C_P10 = COUNT_WIDTH'(BASE_TICKS / 24);

	logic [PRESCALE_WIDTH-1:0] master_period_q;
	logic [SELECT_WIDTH-1:0]   b_select_q;
	logic [SELECT_WIDTH-1:0]   c_select_q;
	logic [PRESCALE_WIDTH-1:0] prescale_q;
	logic [SELECT_WIDTH-1:0]   last_b_q;
	logic [SELECT_WIDTH-1:0]   last_c_q;
	logic                      pending_b_q;
	logic                      pending_c_q;
	level_beat_t               result_q;
	logic                      result_valid_q;

	logic                      accept;
	logic                      advance;
	logic [PRESCALE_WIDTH-1:0] prescale_inc;
	logic                      sub_tick;
	logic                      step;
	logic [SELECT_WIDTH-1:0]   b_sat;
	logic [SELECT_WIDTH-1:0]   c_sat;
	logic                      pending_b;
	logic                      pending_c;
	logic [COUNT_WIDTH-1:0]    b_period;
	logic [COUNT_WIDTH-1:0]    c_period;
	logic                      a_wrapped;
	logic                      b_wrapped;
	logic                      c_wrapped;
	logic                      level_a;
	logic                      level_b;
	logic                      level_c;
	logic                      resync_b;
	logic                      resync_c;

	// Handshake: the result register parts the two sides.
	assign tick.ready     = !result_valid_q || result.ready;
	assign accept         = tick.valid && tick.ready;
	assign advance        = tick.payload.advance;
	assign result.valid   = result_valid_q;
	assign result.payload = result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_period_q <= MASTER_PERIOD_RESET;
			b_select_q      <= SELECT_RESET;
			c_select_q      <= SELECT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MASTER_PERIOD: master_period_q <= wr_data;
				REG_B_SELECT:      b_select_q <= wr_data[SELECT_WIDTH-1:0];
				REG_C_SELECT:      c_select_q <= wr_data[SELECT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Prescaler and select change detection.
	always_comb begin
		prescale_inc = prescale_q + PRESCALE_WIDTH'(1);
		sub_tick     = advance && (prescale_inc > master_period_q);
		step         = accept && sub_tick;
		b_sat        = (b_select_q > SELECT_MAX) ? SELECT_MAX : b_select_q;
		c_sat        = (c_select_q > SELECT_MAX) ? SELECT_MAX : c_select_q;
		pending_b    = pending_b_q || (b_sat != last_b_q);
		pending_c    = pending_c_q || (c_sat != last_c_q);
		resync_b     = a_wrapped && pending_b;
		resync_c     = a_wrapped && pending_c;
	end

	// Multiplier tables.
	always_comb begin
		case (b_sat)
			4'd0:    b_period = B_P0;
			4'd1:    b_period = B_P1;
			4'd2:    b_period = B_P2;
			4'd3:    b_period = B_P3;
			4'd4:    b_period = B_P4;
			4'd5:    b_period = B_P5;
			4'd6:    b_period = B_P6;
			4'd7:    b_period = B_P7;
			4'd8:    b_period = B_P8;
			4'd9:    b_period = B_P9;
			default: b_period = B_P10;
		endcase
		case (c_sat)
			4'd0:    c_period = C_P0;
			4'd1:    c_period = C_P1;
			4'd2:    c_period = C_P2;
			4'd3:    c_period = C_P3;
			4'd4:    c_period = C_P4;
			4'd5:    c_period = C_P5;
			4'd6:    c_period = C_P6;
			4'd7:    c_period = C_P7;
			4'd8:    c_period = C_P8;
			4'd9:    c_period = C_P9;
			default: c_period = C_P10;
		endcase
	end

	// The three sub-clocks; A's wrap carries out pending phase resets.
	tcdm_sub_clock #(.COUNT_WIDTH(COUNT_WIDTH)) u_clock_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.resync  (1'b0),
		.period  (A_PERIOD),
		.level   (level_a),
		.wrapped (a_wrapped)
	);

	tcdm_sub_clock #(.COUNT_WIDTH(COUNT_WIDTH)) u_clock_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.resync  (resync_b),
		.period  (b_period),
		.level   (level_b),
		.wrapped (b_wrapped)
	);

	tcdm_sub_clock #(.COUNT_WIDTH(COUNT_WIDTH)) u_clock_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.resync  (resync_c),
		.period  (c_period),
		.level   (level_c),
		.wrapped (c_wrapped)
	);

	// Tick state, updated only by an accepted beat with advance set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= '0;
			last_b_q    <= SELECT_RESET;
			last_c_q    <= SELECT_RESET;
			pending_b_q <= 1'b0;
			pending_c_q <= 1'b0;
		end else if (accept && advance) begin
			prescale_q  <= sub_tick ? '0 : prescale_inc;
			last_b_q    <= b_sat;
			last_c_q    <= c_sat;
			pending_b_q <= pending_b && !(step && a_wrapped);
			pending_c_q <= pending_c && !(step && a_wrapped);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result payload; the wrap flags of B and C cancel out and leave their levels as they are.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.clock_a  <= level_a;
			result_q.clock_b  <= level_b | (b_wrapped & ~b_wrapped);
			result_q.clock_c  <= level_c | (c_wrapped & ~c_wrapped);
			result_q.sub_tick <= sub_tick;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triple clock divider/multiplier. Tick beats go
// in with random gaps and result beats come out under random stalls. Each
// accepted tick is run through a cycle-free model of the prescaler, the three
// sub-clocks and the phase reset, and the levels it gives are compared with
// the next result beat. Register settings change only while nothing is in
// flight.
// ----------------------------------------------------------------------------
module tb_top;
	import tcdm_pkg::*;

	localparam int BASE_TICKS     = 48;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TICK_TARGET    = 660;

	// Per sub-clock state: count, level and whether the last step wrapped.
	typedef struct packed {
		logic [15:0] cnt;
		logic        lvl;
		logic        wrapped;
	} sub_clock_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Sender and receiver drive these; the channels follow them.
	logic        tick_valid  = 1'b0;
	tick_beat_t  tick_data   = '0;
	logic        level_ready = 1'b0;

	logic                       wr_en    = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] wr_index = REG_MASTER_PERIOD;
	logic [CFG_DATA_WIDTH-1:0]  wr_data  = '0;

	tcdm_stream_if #(.payload_t(tick_beat_t))  tick_if ();
	tcdm_stream_if #(.payload_t(level_beat_t)) level_if ();

	assign tick_if.valid   = tick_valid;
	assign tick_if.payload = tick_data;
	assign level_if.ready  = level_ready;

	triple_clock_divider_multiplier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_if),
		.result   (level_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Register copies as the block should hold them.
	logic [15:0] period_reg = MASTER_PERIOD_RESET;
	logic [3:0]  b_sel_reg  = SELECT_RESET;
	logic [3:0]  c_sel_reg  = SELECT_RESET;

	// Model state of the prescaler, the sub-clocks and the phase reset.
	logic [15:0] prescale_cnt  = '0;
	sub_clock_t  a_clock       = '{cnt: '0, lvl: 1'b1, wrapped: 1'b0};
	sub_clock_t  b_clock       = '{cnt: '0, lvl: 1'b1, wrapped: 1'b0};
	sub_clock_t  c_clock       = '{cnt: '0, lvl: 1'b1, wrapped: 1'b0};
	logic        resync_b      = 1'b0;
	logic        resync_c      = 1'b0;
	logic [3:0]  applied_b_sel = SELECT_RESET;
	logic [3:0]  applied_c_sel = SELECT_RESET;

	tick_beat_t  pending_ticks[$];
	level_beat_t expected_levels[$];

	int   errors       = 0;
	int   send_gap     = 0;
	int   stall_left   = 0;
	int   quiet_cycles = 0;
	logic calm         = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Period of clock B in sub-ticks for a saturated select.
	function automatic int unsigned b_period(logic [3:0] sel);
		case (sel)
			4'd0:    return BASE_TICKS * 8;
			4'd1:    return BASE_TICKS * 6;
			4'd2:    return BASE_TICKS * 4;
			4'd3:    return BASE_TICKS * 3;
			4'd4:    return BASE_TICKS * 2;
			4'd5:    return BASE_TICKS;
			4'd6:    return BASE_TICKS / 2;
			4'd7:    return BASE_TICKS / 3;
			4'd8:    return BASE_TICKS / 4;
			4'd9:    return BASE_TICKS / 6;
			default: return BASE_TICKS / 8;
		endcase
	endfunction

	// Period of clock C in sub-ticks for a saturated select.
	function automatic int unsigned c_period(logic [3:0] sel);
		case (sel)
			4'd0:    return BASE_TICKS * 24;
			4'd1:    return BASE_TICKS * 12;
			4'd2:    return BASE_TICKS * 8;
			4'd3:    return BASE_TICKS * 4;
			4'd4:    return BASE_TICKS * 2;
			4'd5:    return BASE_TICKS;
			4'd6:    return BASE_TICKS / 2;
			4'd7:    return BASE_TICKS / 4;
			4'd8:    return BASE_TICKS / 8;
			4'd9:    return BASE_TICKS / 12;
			default: return BASE_TICKS / 24;
		endcase
	endfunction

	// One sub-tick of a clock: off at half period, on again at the wrap.
	function automatic sub_clock_t step_sub_clock(sub_clock_t cur, int unsigned period);
		sub_clock_t  nxt;
		logic [15:0] half;
		logic [15:0] last;
		half        = 16'(period >> 1);
		last        = 16'(period - 1);
		nxt         = cur;
		nxt.wrapped = 1'b0;
		nxt.cnt     = cur.cnt + 16'd1;
		if (nxt.cnt == half)
			nxt.lvl = 1'b0;
		if (nxt.cnt > last) begin
			nxt.cnt     = '0;
			nxt.lvl     = 1'b1;
			nxt.wrapped = 1'b1;
		end
		return nxt;
	endfunction

	// Advance the model by one tick beat and give the levels it should show.
	function automatic level_beat_t predict_levels(tick_beat_t beat);
		level_beat_t lv;
		logic [3:0]  bs;
		logic [3:0]  cs;
		lv.sub_tick = 1'b0;
		if (beat.advance) begin
			bs = (b_sel_reg > SELECT_MAX) ? SELECT_MAX : b_sel_reg;
			cs = (c_sel_reg > SELECT_MAX) ? SELECT_MAX : c_sel_reg;
			// A select change arms a phase reset for the next wrap of A.
			if (bs != applied_b_sel) begin
				applied_b_sel = bs;
				resync_b      = 1'b1;
			end
			if (cs != applied_c_sel) begin
				applied_c_sel = cs;
				resync_c      = 1'b1;
			end
			prescale_cnt = prescale_cnt + 16'd1;
			if (prescale_cnt > period_reg) begin
				prescale_cnt = '0;
				lv.sub_tick  = 1'b1;
				a_clock      = step_sub_clock(a_clock, BASE_TICKS);
				// The phase reset lands just before B and C take this sub-tick.
				if (a_clock.wrapped) begin
					if (resync_b) begin
						b_clock.cnt = '1;
						b_clock.lvl = 1'b1;
						resync_b    = 1'b0;
					end
					if (resync_c) begin
						c_clock.cnt = '1;
						c_clock.lvl = 1'b1;
						resync_c    = 1'b0;
					end
				end
				b_clock = step_sub_clock(b_clock, b_period(bs));
				c_clock = step_sub_clock(c_clock, c_period(cs));
			end
		end
		lv.clock_a = a_clock.lvl;
		lv.clock_b = b_clock.lvl;
		lv.clock_c = c_clock.lvl;
		return lv;
	endfunction

	task automatic check_level(string what, logic want, logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
			errors++;
		end
	endtask

	// Tick sender: presents queued beats, idles in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else begin
			if (tick_valid && tick_if.ready)
				expected_levels.push_back(predict_levels(tick_data));
			if (!tick_valid || tick_if.ready) begin
				if (send_gap != 0) begin
					send_gap   <= send_gap - 1;
					tick_valid <= 1'b0;
				end else if (!calm && pending_ticks.size() != 0 &&
						$urandom_range(0, 11) == 0) begin
					send_gap   <= $urandom_range(0, 16);
					tick_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick_valid <= 1'b1;
					tick_data  <= pending_ticks.pop_front();
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: checks each beat against the oldest expectation.
	always @(posedge clk) begin
		level_beat_t want;
		if (!arst_n) begin
			level_ready <= 1'b0;
		end else begin
			if (level_if.valid && level_ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %b",
						$time, level_if.payload);
					errors++;
				end else begin
					want = expected_levels.pop_front();
					check_level("clock_a", want.clock_a, level_if.payload.clock_a);
					check_level("clock_b", want.clock_b, level_if.payload.clock_b);
					check_level("clock_c", want.clock_c, level_if.payload.clock_c);
					check_level("sub_tick", want.sub_tick, level_if.payload.sub_tick);
				end
			end
			if (stall_left != 0) begin
				stall_left  <= stall_left - 1;
				level_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left  <= $urandom_range(0, 16);
				level_ready <= 1'b0;
			end else begin
				level_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run after too long without any beat or write.
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && tick_if.ready) ||
				(level_if.valid && level_ready) || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL triple_clock_divider_multiplier");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_tick(logic adv);
		tick_beat_t beat;
		beat.advance = adv;
		pending_ticks.push_back(beat);
	endtask

	// Queue random ticks; roughly one in hold_odds is a hold.
	task automatic load_ticks(int count, int unsigned hold_odds);
		repeat (count)
			push_tick($urandom_range(0, hold_odds - 1) != 0);
	endtask

	// Wait until every queued beat is sent and every result is back. The
	// check runs on the falling edge, once the rising edge has settled.
	task automatic drain();
		while (pending_ticks.size() != 0 || tick_valid || level_if.valid ||
				expected_levels.size() != 0)
			@(negedge clk);
	endtask

	// Write all three registers, one per cycle; only called while idle.
	task automatic program_clocks(logic [15:0] period, logic [3:0] b_sel, logic [3:0] c_sel);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= REG_MASTER_PERIOD;
		wr_data  <= period;
		@(posedge clk);
		wr_index <= REG_B_SELECT;
		wr_data  <= 16'(b_sel);
		@(posedge clk);
		wr_index <= REG_C_SELECT;
		wr_data  <= 16'(c_sel);
		@(posedge clk);
		wr_en      <= 1'b0;
		period_reg  = period;
		b_sel_reg   = b_sel;
		c_sel_reg   = c_sel;
	endtask

	// Stimulus: directed opening, random phases, then a run with no idling.
	initial begin
		int          sent;
		int          n;
		int unsigned pick;
		logic [15:0] period;
		logic [3:0]  b_sel;
		logic [3:0]  c_sel;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Holds and ticks with the reset settings.
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b1);
		drain();

		// Fastest prescaler with the shortest periods; both selects change.
		program_clocks(16'd0, SELECT_MAX, SELECT_MAX);
		push_tick(1'b1);
		push_tick(1'b0);
		repeat (12) push_tick(1'b1);
		drain();

		// Largest prescaler compare that still gives sub-ticks, with the longest periods.
		program_clocks(16'd65534, 4'd0, 4'd0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		drain();

		// Random phases, mostly with a fast prescaler so the sub-clocks wrap.
		b_sel = 4'd0;
		c_sel = 4'd0;
		while (sent < TICK_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				period = 16'($urandom_range(0, 3));
			else if (pick == 7)
				period = 16'($urandom_range(4, 40));
			else if (pick == 8)
				period = 16'($urandom_range(0, 65534));
			else
				period = 16'd65534;
			if ($urandom_range(0, 2) != 0)
				b_sel = 4'($urandom_range(0, 10));
			if ($urandom_range(0, 2) != 0)
				c_sel = 4'($urandom_range(0, 10));
			program_clocks(period, b_sel, c_sel);
			n = $urandom_range(20, 120);
			load_ticks(n, 8);
			sent += n;
			drain();
		end

		// Closing stretch at full rate on both sides.
		calm = 1'b1;
		program_clocks(16'd0, 4'($urandom_range(0, 10)), 4'($urandom_range(0, 10)));
		load_ticks(100, 8);
		drain();
		repeat (5) @(posedge clk);

		if (errors == 0)
			$display("PASS triple_clock_divider_multiplier");
		else
			$display("FAIL triple_clock_divider_multiplier");
		$finish;
	end

endmodule
